@@ rtl/fpw_pkg.sv @@
// ============================================================================
// fpw_pkg: shared types and constants for the four-level page walker
// Address field widths, result codes and the command passed front to back.
// ============================================================================
package fpw_pkg;

    localparam int FRAME_BITS  = 24;
    localparam int PAGE_SHIFT  = 12;
    localparam int INDEX_BITS  = 9;
    localparam int ENTRY_SHIFT = 3;
    localparam int VA_BITS     = 48;
    localparam int ADDR_BITS   = 64;
    localparam int DATA_BITS   = 64;
    localparam int LEVEL_BITS  = 3;

    localparam logic [LEVEL_BITS-1:0] LEVEL_ROOT  = 3'd0;
    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE   = 3'd1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_TWO   = 3'd2;
    localparam logic [LEVEL_BITS-1:0] LEVEL_FINAL = 3'd3;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_RESP  = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_PHYS = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [ADDR_BITS-1:0]  base;
        logic [PAGE_SHIFT-1:0] addend;
    } t_cmd;

endpackage

@@ rtl/fpw_front.sv @@
// ============================================================================
// fpw_front: transaction intake and walk sequencing
// Tracks walk level and held address, drops stray transactions and emits
// a base/addend command for each result.
// ============================================================================
module fpw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [fpw_pkg::DATA_BITS-1:0] i_cfg_data,
    input  logic                          i_take,
    input  logic                          i_req_type,
    input  logic [fpw_pkg::VA_BITS-1:0]   i_virtual_address,
    input  logic [fpw_pkg::DATA_BITS-1:0] i_read_data,
    output logic                          o_cmd_valid,
    output fpw_pkg::t_cmd                 o_cmd
);
    import fpw_pkg::*;

    logic [DATA_BITS-1:0]  r_root;
    logic                  r_busy;
    logic [LEVEL_BITS-1:0] r_level;
    logic [VA_BITS-1:0]    r_held;

    logic                  n_busy;
    logic [LEVEL_BITS-1:0] n_level;
    logic                  latch_va;
    logic [INDEX_BITS-1:0] next_idx;
    logic [ADDR_BITS-1:0]  entry_page;
    logic [ADDR_BITS-1:0]  root_page;

    assign entry_page = ADDR_BITS'(i_read_data[PAGE_SHIFT +: FRAME_BITS]) << PAGE_SHIFT;
    assign root_page  = {r_root[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

    always_comb begin
        unique case (r_level)
            LEVEL_ROOT: next_idx = r_held[PAGE_SHIFT + 2*INDEX_BITS +: INDEX_BITS];
            LEVEL_ONE:  next_idx = r_held[PAGE_SHIFT + INDEX_BITS +: INDEX_BITS];
            LEVEL_TWO:  next_idx = r_held[PAGE_SHIFT +: INDEX_BITS];
            default:    next_idx = '0;
        endcase
    end

    always_comb begin
        n_busy      = r_busy;
        n_level     = r_level;
        latch_va    = 1'b0;
        o_cmd_valid = 1'b0;
        o_cmd       = '{kind: KIND_READ, base: entry_page,
                        addend: {next_idx, {ENTRY_SHIFT{1'b0}}}};
        if (i_take) begin
            if (i_req_type == REQ_START) begin
                if (!r_busy) begin
                    latch_va    = 1'b1;
                    n_busy      = 1'b1;
                    n_level     = LEVEL_ROOT;
                    o_cmd_valid = 1'b1;
                    o_cmd.base  = root_page;
                    o_cmd.addend = {i_virtual_address[VA_BITS-INDEX_BITS +: INDEX_BITS],
                                    {ENTRY_SHIFT{1'b0}}};
                end
            end else if (r_busy) begin
                o_cmd_valid = 1'b1;
                if (r_level >= LEVEL_FINAL) begin
                    n_busy       = 1'b0;
                    n_level      = LEVEL_ROOT;
                    o_cmd.kind   = KIND_PHYS;
                    o_cmd.addend = r_held[PAGE_SHIFT-1:0];
                end else begin
                    n_level = r_level + LEVEL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_busy  <= 1'b0;
            r_level <= LEVEL_ROOT;
            r_held  <= '0;
        end else begin
            if (i_cfg_valid) r_root <= i_cfg_data;
            r_busy  <= n_busy;
            r_level <= n_level;
            if (latch_va) r_held <= i_virtual_address;
        end
    end

endmodule

@@ rtl/fpw_cmdq.sv @@
// ============================================================================
// fpw_cmdq: two-entry command queue
// Decouples the intake side from the address adder and output register.
// ============================================================================
module fpw_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  fpw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output fpw_pkg::t_cmd o_cmd
);
    import fpw_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) r_slot[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_wr) r_wptr <= !r_wptr;
            if (do_rd) r_rptr <= !r_rptr;
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/fpw_back.sv @@
// ============================================================================
// fpw_back: address adder and result register
// Forms base plus addend for each command and holds it until popped.
// ============================================================================
module fpw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  fpw_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_take,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_result_kind,
    output logic [fpw_pkg::ADDR_BITS-1:0] o_address
);
    import fpw_pkg::*;

    logic                 r_valid;
    logic                 r_kind;
    logic [ADDR_BITS-1:0] r_addr;

    assign o_cmd_take    = i_cmd_valid && (!r_valid || i_pop);
    assign o_empty       = !r_valid;
    assign o_result_kind = r_kind;
    assign o_address     = r_addr;

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_kind <= i_cmd.kind;
            r_addr <= i_cmd.base + ADDR_BITS'(i_cmd.addend);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

@@ rtl/four_level_page_walk.sv @@
// ============================================================================
// four_level_page_walk: 48-bit four-level page table walker
// Path: an accepted transaction's command is registered in the command
// queue, then in the result register, from which it can be popped.
// Throughput: one transaction per cycle while full is low; full rises
// when the two-entry command queue backs up behind an unpopped result.
// Reset: synchronous, clears walk state, root base, queue and result valid.
// ============================================================================
module four_level_page_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fpw_pkg::DATA_BITS-1:0] i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_req_type,
    input  logic [fpw_pkg::VA_BITS-1:0]   i_virtual_address,
    input  logic [fpw_pkg::DATA_BITS-1:0] i_read_data,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_result_kind,
    output logic [fpw_pkg::ADDR_BITS-1:0] o_address
);
    import fpw_pkg::*;

    logic f_cmd_valid;
    t_cmd f_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic b_take;
    logic take;

    assign o_cfg_ready = 1'b1;
    assign take        = push && !full;

    fpw_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_take            (take),
        .i_req_type        (i_req_type),
        .i_virtual_address (i_virtual_address),
        .i_read_data       (i_read_data),
        .o_cmd_valid       (f_cmd_valid),
        .o_cmd             (f_cmd)
    );

    fpw_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_cmd_valid),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_rd    (b_take),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    fpw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_take    (b_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result_kind (o_result_kind),
        .o_address     (o_address)
    );

endmodule

@@ rtl/fpw_checker.sv @@
// ============================================================================
// fpw_checker: port-level checks for the page walker
// Reset state, queue backpressure, config readiness and held result behavior.
// ============================================================================
module fpw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic                          o_result_kind,
    input logic [fpw_pkg::ADDR_BITS-1:0] o_address
);
    import fpw_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_full_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input side full while no result is waiting");

    a_cfg_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_address) && $stable(o_result_kind))
        else $error("waiting result changed before pop");

endmodule

bind four_level_page_walk fpw_checker u_fpw_checker (.*);
